FILE: design/rwc_pkg.sv
// Shared types and constants for the replay window checker.
`timescale 1ns / 1ps

package rwc_pkg;

  localparam int WINDOW_BITS = 64;
  localparam int SEQ_W       = 64;
  localparam int SLOT_W      = 8;
  localparam int LEN_W       = 16;
  localparam int SLOT_SPACE  = 256;  // slots addressable through an 8-bit index

  localparam logic [LEN_W-1:0] MIN_FRAME_BYTES = 16'd28;

  typedef enum logic [1:0] {
    REQ_CHECK  = 2'd0,
    REQ_SETUP  = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NOT_READY = 3'd2,
    ST_TOO_OLD   = 3'd3,
    ST_REPLAY    = 3'd4
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the request and read the slot's window
    logic eval;      // register sequence compare and distance
    logic commit;    // decide, update state, register the result
    logic load_out;  // move the result into the output register
  } cmd_t;

endpackage

FILE: design/replay_window_checker_top.sv
// Top level of the per-client anti-replay window checker.
`timescale 1ns / 1ps
//
// Input channel in_*: one request per transfer. in_tuser carries the request
// kind (check packet, set up client, remove client). in_tdata carries the
// client slot, the 64-bit packet sequence number and the frame length.
// Result channel out_*: exactly one result per request, in request order,
// carrying the accepted flag and a status code.
// Each request passes through accept (slot window read from the window
// memory), evaluate (64-bit sequence compare), update (window write-back) and
// hand-off to the output register, in that order. out_tvalid rises once the
// hand-off step has loaded the result; a new request is accepted only after
// the previous one has left the send step. The window memory's single read and
// write port and the read-modify-write per slot keep requests from overlapping.
// Reset clears all ready flags at once; windows of slots need no clearing,
// since a slot must be set up (which zeroes its window) before it is checked.
// When the receiver stalls, the result waits in the output register; the next
// request is still taken and evaluated, then held in the send step with
// in_tready low until the waiting result is taken.

module replay_window_checker_top #(
  parameter int CLIENT_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  input  logic [87:0] in_tdata,   // [7:0] client_slot, [71:8] sequence_req, [87:72] frame_length
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] accepted, [3:1] status, [7:4] zero
);

  localparam int SLOTS_USED = (CLIENT_SLOTS < rwc_pkg::SLOT_SPACE) ?
                              CLIENT_SLOTS : rwc_pkg::SLOT_SPACE;
  localparam int IDX_W      = (SLOTS_USED > 1) ? $clog2(SLOTS_USED) : 1;

  rwc_pkg::cmd_t cmd;

  rwc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  rwc_datapath #(
    .SLOTS (SLOTS_USED),
    .IDX_W (IDX_W)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

FILE: design/rwc_ctrl.sv
// Controller state machine: sequences accept, evaluate, update and send.
`timescale 1ns / 1ps

module rwc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output rwc_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_UPD,
    S_SEND
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    cmd.capture  = (state_r == S_IDLE) && in_tvalid;
    cmd.eval     = (state_r == S_EVAL);
    cmd.commit   = (state_r == S_UPD);
    cmd.load_out = (state_r == S_SEND) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EVAL;
      end
      S_EVAL: state_nxt = S_UPD;
      S_UPD:  state_nxt = S_SEND;
      S_SEND: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EVAL))
    else $error("accepted request did not move to evaluate");

  a_upd_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> ($past(state_r) == S_EVAL))
    else $error("update step without evaluate step");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result loaded over an untaken result");

  a_valid_from_send: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_SEND))
    else $error("result shown outside send step");

endmodule

FILE: design/rwc_datapath.sv
// Datapath: request registers, window memory, ready flags and decision logic.
`timescale 1ns / 1ps

module rwc_datapath #(
  parameter int SLOTS = 256,
  parameter int IDX_W = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rwc_pkg::cmd_t cmd,
  input  logic [1:0]    in_tuser,
  input  logic [87:0]   in_tdata,
  output logic [7:0]    out_tdata
);

  localparam int WORD_W = rwc_pkg::SEQ_W + rwc_pkg::WINDOW_BITS;
  localparam int DLO_W  = $clog2(rwc_pkg::WINDOW_BITS);

  // Window memory word: {highest sequence, seen bitmap}
  logic [WORD_W-1:0] win_mem [SLOTS];
  logic [WORD_W-1:0] rd_q;

  logic [SLOTS-1:0] ready_r;

  logic [1:0]                  req_r;
  logic [rwc_pkg::SLOT_W-1:0]  slot_r;
  logic [rwc_pkg::SEQ_W-1:0]   seq_r;
  logic [rwc_pkg::LEN_W-1:0]   len_r;

  logic             gt_r;
  logic             far_r;
  logic [DLO_W-1:0] dlo_r;

  logic [3:0] res_r;
  logic [3:0] out_q;

  logic [rwc_pkg::SEQ_W-1:0]       hi;
  logic [rwc_pkg::WINDOW_BITS-1:0] bm;
  logic [rwc_pkg::SEQ_W:0]         up;
  logic [rwc_pkg::SEQ_W-1:0]       dn;
  logic [rwc_pkg::SEQ_W-1:0]       gap;
  logic                            gt;

  logic                            in_range;
  logic                            slot_ok;
  logic                            acc;
  rwc_pkg::status_t                st;
  logic                            mem_we;
  logic [rwc_pkg::SEQ_W-1:0]       hi_new;
  logic [rwc_pkg::WINDOW_BITS-1:0] bm_new;
  logic                            rdy_we;
  logic                            rdy_val;

  assign hi = rd_q[WORD_W-1:rwc_pkg::WINDOW_BITS];
  assign bm = rd_q[rwc_pkg::WINDOW_BITS-1:0];

  // Both distances in parallel; borrow of seq - hi gives the order
  assign up  = {1'b0, seq_r} - {1'b0, hi};
  assign dn  = hi - seq_r;
  assign gt  = !up[rwc_pkg::SEQ_W] && (|up[rwc_pkg::SEQ_W-1:0]);
  assign gap = gt ? up[rwc_pkg::SEQ_W-1:0] : dn;

  assign in_range = ({1'b0, slot_r} < 9'(SLOTS));
  assign slot_ok  = in_range && ready_r[slot_r[IDX_W-1:0]];

  always_comb begin
    acc     = 1'b0;
    st      = rwc_pkg::ST_OK;
    mem_we  = 1'b0;
    hi_new  = '0;
    bm_new  = '0;
    rdy_we  = 1'b0;
    rdy_val = 1'b0;
    case (rwc_pkg::req_t'(req_r))
      rwc_pkg::REQ_CHECK: begin
        if (len_r < rwc_pkg::MIN_FRAME_BYTES) begin
          st = rwc_pkg::ST_SHORT;
        end else if (!slot_ok) begin
          st = rwc_pkg::ST_NOT_READY;
        end else if (gt_r) begin
          acc    = 1'b1;
          mem_we = 1'b1;
          hi_new = seq_r;
          bm_new = (far_r ? '0 : (bm << dlo_r)) | {{(rwc_pkg::WINDOW_BITS-1){1'b0}}, 1'b1};
        end else if (far_r) begin
          st = rwc_pkg::ST_TOO_OLD;
        end else if (bm[dlo_r]) begin
          st = rwc_pkg::ST_REPLAY;
        end else begin
          acc    = 1'b1;
          mem_we = 1'b1;
          hi_new = hi;
          bm_new = bm | ({{(rwc_pkg::WINDOW_BITS-1){1'b0}}, 1'b1} << dlo_r);
        end
      end
      rwc_pkg::REQ_SETUP: begin
        if (in_range) begin
          acc     = 1'b1;
          mem_we  = 1'b1;
          rdy_we  = 1'b1;
          rdy_val = 1'b1;
        end else begin
          st = rwc_pkg::ST_NOT_READY;
        end
      end
      rwc_pkg::REQ_REMOVE: begin
        if (in_range) begin
          acc    = 1'b1;
          rdy_we = 1'b1;
        end else begin
          st = rwc_pkg::ST_NOT_READY;
        end
      end
      default: begin
        acc = 1'b0;
        st  = rwc_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_tuser;
      slot_r <= in_tdata[7:0];
      seq_r  <= in_tdata[71:8];
      len_r  <= in_tdata[87:72];
    end
    if (cmd.eval) begin
      gt_r  <= gt;
      far_r <= |gap[rwc_pkg::SEQ_W-1:DLO_W];
      dlo_r <= gap[DLO_W-1:0];
    end
    if (cmd.commit) begin
      res_r <= {st, acc};
    end
    if (cmd.load_out) begin
      out_q <= res_r;
    end
  end

  // Window memory: one read port at accept, one write port at commit
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_q <= win_mem[in_tdata[IDX_W-1:0]];
    end
    if (cmd.commit && mem_we) begin
      win_mem[slot_r[IDX_W-1:0]] <= {hi_new, bm_new};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= '0;
    end else if (cmd.commit && rdy_we) begin
      ready_r[slot_r[IDX_W-1:0]] <= rdy_val;
    end
  end

  assign out_tdata = {4'b0000, out_q};

endmodule
